/* sv/utf8cd_pkg.sv */
// Package for the UTF-8 code point decoder: widths, status and halt codes,
// decoder state and result types. No dependencies.
package utf8cd_pkg;

    localparam int COUNT_BITS     = 12;
    localparam int CFG_BITS       = 12;
    localparam int OUT_COUNT_BITS = 12;
    localparam int POINT_BITS     = 21;
    localparam int CMP_BITS       = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
    localparam int WIDE_BITS      = (CMP_BITS > OUT_COUNT_BITS) ? CMP_BITS : OUT_COUNT_BITS;

    localparam logic [2:0] ST_PENDING = 3'd0;
    localparam logic [2:0] ST_READY   = 3'd1;
    localparam logic [2:0] ST_DONE    = 3'd2;
    localparam logic [2:0] ST_ERROR   = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    localparam logic [1:0] HALT_NONE  = 2'd0;
    localparam logic [1:0] HALT_ERROR = 2'd1;
    localparam logic [1:0] HALT_LIMIT = 2'd2;

    localparam logic [CFG_BITS-1:0] CFG_RESET = {CFG_BITS{1'b1}};

    typedef struct packed {
        logic [POINT_BITS-1:0] partial_point;
        logic [1:0]            bytes_due;
        logic [COUNT_BITS-1:0] emitted_count;
        logic [1:0]            halt_mode;
    } dec_state_t;

    typedef struct packed {
        logic [2:0]                status;
        logic [POINT_BITS-1:0]     code_point;
        logic [OUT_COUNT_BITS-1:0] point_count;
    } dec_result_t;

    localparam dec_state_t STATE_CLEAR = '{
        partial_point: '0,
        bytes_due:     2'd0,
        emitted_count: '0,
        halt_mode:     HALT_NONE
    };

    // Bring the internal counter onto the output count width.
    function automatic logic [OUT_COUNT_BITS-1:0] count_out(
        input logic [COUNT_BITS-1:0] cnt
    );
        logic [WIDE_BITS-1:0] wide;
        wide = WIDE_BITS'(cnt);
        return wide[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

/* sv/utf8cd_step.sv */
// One decode step of the UTF-8 code point decoder: current state, one byte
// and the limit in; next state and the result out. Uses utf8cd_pkg.
module utf8cd_step (
    input  utf8cd_pkg::dec_state_t               cur,
    input  logic [7:0]                           byte_in,
    input  logic [utf8cd_pkg::CFG_BITS-1:0]      max_points,
    output utf8cd_pkg::dec_state_t               nxt,
    output utf8cd_pkg::dec_result_t              res
);

    logic [utf8cd_pkg::CMP_BITS-1:0]   cnt_cmp;
    logic [utf8cd_pkg::CMP_BITS-1:0]   max_cmp;
    logic                              limit_hit;
    logic [utf8cd_pkg::COUNT_BITS-1:0] cnt_inc;
    logic [utf8cd_pkg::POINT_BITS-1:0] shifted;
    logic                              is_nul;

    assign cnt_cmp   = utf8cd_pkg::CMP_BITS'(cur.emitted_count);
    assign max_cmp   = utf8cd_pkg::CMP_BITS'(max_points);
    assign limit_hit = (cnt_cmp >= max_cmp) || (&cur.emitted_count);
    assign cnt_inc   = cur.emitted_count + utf8cd_pkg::COUNT_BITS'(1);
    assign shifted   = {cur.partial_point[utf8cd_pkg::POINT_BITS-7:0], byte_in[5:0]};
    assign is_nul    = (byte_in == 8'h00);

    always_comb
    begin
        logic [utf8cd_pkg::COUNT_BITS-1:0] cnt_rep;
        nxt            = cur;
        res.status     = utf8cd_pkg::ST_PENDING;
        res.code_point = '0;
        cnt_rep        = cur.emitted_count;

        if (cur.halt_mode != utf8cd_pkg::HALT_NONE)
        begin
            res.status = utf8cd_pkg::ST_IGNORED;
            if (is_nul)
            begin
                if (cur.halt_mode == utf8cd_pkg::HALT_LIMIT)
                    res.status = utf8cd_pkg::ST_DONE;
                nxt = utf8cd_pkg::STATE_CLEAR;
            end
        end
        else if (cur.bytes_due == 2'd0)
        begin
            if (is_nul)
            begin
                res.status = utf8cd_pkg::ST_DONE;
                nxt        = utf8cd_pkg::STATE_CLEAR;
            end
            else if (limit_hit)
            begin
                res.status    = utf8cd_pkg::ST_IGNORED;
                nxt.halt_mode = utf8cd_pkg::HALT_LIMIT;
            end
            else if (byte_in[7] == 1'b0)
            begin
                res.status        = utf8cd_pkg::ST_READY;
                res.code_point    = utf8cd_pkg::POINT_BITS'(byte_in);
                nxt.emitted_count = cnt_inc;
                cnt_rep           = cnt_inc;
            end
            else if (byte_in[7:5] == 3'b110)
            begin
                nxt.partial_point = utf8cd_pkg::POINT_BITS'(byte_in[4:0]);
                nxt.bytes_due     = 2'd1;
            end
            else if (byte_in[7:4] == 4'b1110)
            begin
                nxt.partial_point = utf8cd_pkg::POINT_BITS'(byte_in[3:0]);
                nxt.bytes_due     = 2'd2;
            end
            else if (byte_in[7:3] == 5'b11110)
            begin
                nxt.partial_point = utf8cd_pkg::POINT_BITS'(byte_in[2:0]);
                nxt.bytes_due     = 2'd3;
            end
            else
            begin
                res.status    = utf8cd_pkg::ST_ERROR;
                nxt.halt_mode = utf8cd_pkg::HALT_ERROR;
            end
        end
        else
        begin
            if (is_nul)
            begin
                res.status = utf8cd_pkg::ST_ERROR;
                nxt        = utf8cd_pkg::STATE_CLEAR;
            end
            else if (byte_in[7:6] != 2'b10)
            begin
                // Drop the partial code point and halt until NUL.
                res.status        = utf8cd_pkg::ST_ERROR;
                nxt.halt_mode     = utf8cd_pkg::HALT_ERROR;
                nxt.partial_point = '0;
                nxt.bytes_due     = 2'd0;
            end
            else if (cur.bytes_due == 2'd1)
            begin
                res.status        = utf8cd_pkg::ST_READY;
                res.code_point    = shifted;
                nxt.partial_point = '0;
                nxt.bytes_due     = 2'd0;
                nxt.emitted_count = cnt_inc;
                cnt_rep           = cnt_inc;
            end
            else
            begin
                nxt.partial_point = shifted;
                nxt.bytes_due     = cur.bytes_due - 2'd1;
            end
        end

        res.point_count = utf8cd_pkg::count_out(cnt_rep);
    end

endmodule

/* sv/utf8_codepoint_decoder.sv */
// Top level of the UTF-8 code point decoder: input register, decoder state,
// result register and limit register. Uses utf8cd_pkg and utf8cd_step.

// Decodes a NUL-terminated UTF-8 byte stream, one byte per transaction, and
// returns exactly one result transaction per byte: status 0 while a multi-byte
// sequence is pending, 1 with code_point when a 1- to 4-byte sequence
// completes, 2 with the final point_count at the terminating NUL, 3 on an
// invalid lead or continuation byte (a NUL inside a sequence also counts as
// bad and ends the string), and 4 for bytes ignored after an error or after
// max_codepoints code points. No overlong or surrogate checks are made, so
// code_point can reach 21 bits. Throughput is one byte per clock while the
// result register drains (out_ready high): a byte sits in the input register,
// then the decode step updates the decoder state and loads the result register
// in the same cycle, once that register is free or draining. The input
// register takes a new byte whenever it is empty or its byte moves on; the
// result register holds while out_ready is low. Write max_codepoints
// (cfg_we/cfg_wdata) only while no bytes are in flight; it resets to 4095.
module utf8_codepoint_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [utf8cd_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            data_byte,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [2:0]                            status,
    output logic [utf8cd_pkg::POINT_BITS-1:0]     code_point,
    output logic [utf8cd_pkg::OUT_COUNT_BITS-1:0] point_count
);

    logic [utf8cd_pkg::CFG_BITS-1:0] max_reg;

    // Input register.
    logic       in_vld_reg;
    logic       in_vld_next;
    logic [7:0] in_byte_reg;

    // Decoder state.
    utf8cd_pkg::dec_state_t  state_reg;
    utf8cd_pkg::dec_state_t  state_next;
    utf8cd_pkg::dec_result_t step_res;

    // Result register.
    logic                    out_vld_reg;
    logic                    out_vld_next;
    utf8cd_pkg::dec_result_t res_reg;

    logic in_take;
    logic fire;

    // Process the held byte when the result register is free or draining.
    assign fire     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || fire;
    assign in_take  = in_valid && in_ready;

    assign in_vld_next  = in_take || (in_vld_reg && !fire);
    assign out_vld_next = fire || (out_vld_reg && !out_ready);

    utf8cd_step u_step (
        .cur        (state_reg),
        .byte_in    (in_byte_reg),
        .max_points (max_reg),
        .nxt        (state_next),
        .res        (step_res)
    );

    // Limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= utf8cd_pkg::CFG_RESET;
        else if (cfg_we)
            max_reg <= cfg_wdata;
    end

    // Control and decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= utf8cd_pkg::STATE_CLEAR;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    // Payload registers: hold the byte until decoded, hold the result until taken.
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= data_byte;
        if (fire)
            res_reg <= step_res;
    end

    assign out_valid   = out_vld_reg;
    assign status      = res_reg.status;
    assign code_point  = res_reg.code_point;
    assign point_count = res_reg.point_count;

endmodule
